// ===== hdl/lrupr_pkg.sv =====
`timescale 1ns / 1ps

package lrupr_pkg;

  localparam int REF_W   = 16;
  localparam int OCC_W   = 4;
  localparam int FAULT_W = 16;
  localparam int LIMIT_W = 4;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(8);
  localparam logic [FAULT_W-1:0]  FAULT_MAX   = {FAULT_W{1'b1}};

  typedef struct packed {
    logic [REF_W-1:0] page_ref;
    logic             end_of_string;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [REF_W-1:0]   evicted_page;
    logic [OCC_W-1:0]   occupied;
    logic [FAULT_W-1:0] fault_total;
    logic               last;
  } rsp_t;

endpackage

// ===== hdl/lrupr_cell.sv =====
`timescale 1ns / 1ps

// One slot of the recency chain. Slot 0 is the most recent page.
// A slot loads its upstream neighbor's page when no slot upstream matched
// and it lies inside the region that moves down by one.
module lrupr_cell #(
  parameter int IDX     = 0,
  parameter int PAGE_W  = 16,
  parameter int COUNT_W = 4
) (
  input  logic               clk,
  input  logic               take,
  input  logic [PAGE_W-1:0]  ref_page,
  input  logic [PAGE_W-1:0]  prev_page,
  input  logic               match_in,
  input  logic [COUNT_W-1:0] count,
  input  logic               full,
  output logic [PAGE_W-1:0]  page,
  output logic               match_out
);

  logic valid;
  logic match_here;
  logic shift;

  assign valid      = COUNT_W'(IDX) < count;
  assign match_here = valid && (page == ref_page);
  assign match_out  = match_in || match_here;
  // open slot takes part only on a miss with room left
  assign shift = !match_in && (valid || (!full && (COUNT_W'(IDX) == count)));

  always_ff @(posedge clk) begin
    if (take && shift) begin
      page <= prev_page;
    end
  end

endmodule

// ===== hdl/lru_page_replacement.sv =====
`timescale 1ns / 1ps

// LRU page replacement unit.
// Input: a reference word (page_ref, end_of_string) is taken on a clock edge
// with start high and busy low. busy stays low, so a new reference may be
// issued every cycle.
// Output: exactly one result word per reference, shown on result for one
// cycle with done high, in the cycle after the reference was taken. The result
// register loads only on an accepted reference; there is no back-pressure, so
// the receiver must capture the word while done is high.
// Throughput is one reference per cycle: the resident pages sit in a row of
// FRAMES slots, most recent first, that compare against the reference in
// parallel and move down by one together. A match-seen flag ripples
// through the row, so the row length sets the critical path.
// Config: cfg_we writes frames_in_use (0 acts as 1, above FRAMES acts as
// FRAMES); write only while no reference is in flight.
// Reset (synchronous, rst high) empties the list, clears the fault count and
// sets frames_in_use to 8. A result with last set empties the list and
// clears the fault count after it is produced.
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  lrupr_pkg::req_t                   request,
  output logic                              done,
  output lrupr_pkg::rsp_t                   result,
  input  logic                              cfg_we,
  input  logic [lrupr_pkg::LIMIT_W-1:0]     cfg_data
);

  localparam int COUNT_W = $clog2(FRAMES + 1);
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LIM_W   = (COUNT_W > lrupr_pkg::LIMIT_W) ? COUNT_W : lrupr_pkg::LIMIT_W;

  logic [lrupr_pkg::LIMIT_W-1:0]  frames_in_use;
  logic [COUNT_W-1:0]             count;
  logic [COUNT_W-1:0]             count_next;
  logic [lrupr_pkg::FAULT_W-1:0]  faults;
  logic [lrupr_pkg::FAULT_W-1:0]  faults_next;

  logic [PAGE_BITS-1:0] ref_page;
  logic [PAGE_BITS-1:0] pages [FRAMES];
  logic [PAGE_BITS-1:0] chain_page [FRAMES];
  logic                 chain_match [FRAMES+1];

  logic [LIM_W-1:0] lim_raw;
  logic [LIM_W-1:0] lim;
  logic             full;
  logic             take;
  logic             hit;
  logic             evict;
  logic [IDX_W-1:0] evict_idx;
  logic [PAGE_BITS-1:0] evict_page;

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign ref_page = PAGE_BITS'(request.page_ref);

  always_comb begin
    lim_raw = LIM_W'(frames_in_use);
    if (lim_raw == '0) begin
      lim = LIM_W'(1);
    end else if (lim_raw > LIM_W'(FRAMES)) begin
      lim = LIM_W'(FRAMES);
    end else begin
      lim = lim_raw;
    end
  end

  assign full = LIM_W'(count) >= lim;

  assign chain_page[0]  = ref_page;
  assign chain_match[0] = 1'b0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    lrupr_cell #(
      .IDX     (i),
      .PAGE_W  (PAGE_BITS),
      .COUNT_W (COUNT_W)
    ) u_cell (
      .clk       (clk),
      .take      (take),
      .ref_page  (ref_page),
      .prev_page (chain_page[i]),
      .match_in  (chain_match[i]),
      .count     (count),
      .full      (full),
      .page      (pages[i]),
      .match_out (chain_match[i+1])
    );
    if (i < FRAMES - 1) begin : g_link
      assign chain_page[i+1] = pages[i];
    end
  end

  assign hit        = chain_match[FRAMES];
  assign evict      = !hit && full;
  // oldest resident page sits in the last valid slot
  assign evict_idx  = IDX_W'(count - COUNT_W'(1));
  assign evict_page = pages[evict_idx];

  always_comb begin
    count_next = count;
    if (!hit && !full) begin
      count_next = count + COUNT_W'(1);
    end
    faults_next = faults;
    if (!hit && (faults != lrupr_pkg::FAULT_MAX)) begin
      faults_next = faults + lrupr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::LIMIT_RESET;
      count         <= '0;
      faults        <= '0;
      done          <= 1'b0;
    end else begin
      done <= take;
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (take) begin
        if (request.end_of_string) begin
          count  <= '0;
          faults <= '0;
        end else begin
          count  <= count_next;
          faults <= faults_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.hit           <= hit;
      result.evicted_valid <= evict;
      result.evicted_page  <= evict ? lrupr_pkg::REF_W'(evict_page) : '0;
      result.occupied      <= lrupr_pkg::OCC_W'(count_next);
      result.fault_total   <= faults_next;
      result.last          <= request.end_of_string;
    end
  end

endmodule

// ===== hdl/lrupr_checker.sv =====
`timescale 1ns / 1ps

module lrupr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input lrupr_pkg::req_t               request,
  input logic                          done,
  input lrupr_pkg::rsp_t               result
);

  // every taken word yields its result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("no result one cycle after an accepted word");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start) && !$past(busy) && !$past(rst)))
    else $error("result without an accepted word");

  a_last_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.last == $past(request.end_of_string)))
    else $error("last does not echo end_of_string");

  // an eviction is always a fault, and no page means zero
  a_evict_fields: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.evicted_valid ? (!result.hit && result.occupied != '0)
                                   : (result.evicted_page == '0)))
    else $error("inconsistent eviction fields");

  // first reference after the end of a string always faults into an empty list
  a_fresh_string: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && $past(result.last)) |->
      (!result.hit && result.fault_total == lrupr_pkg::FAULT_W'(1)))
    else $error("state not cleared after end of string");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .request  (request),
  .done     (done),
  .result   (result)
);
